// ----- design/aapp_pkg.sv -----
package aapp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SYS_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_BIAS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIA_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIA_BIAS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIA_SCALE = 3'd4;

  localparam logic [CFG_DATA_W-1:0] DIA_SCALE_RESET = 32'h0001_0000;

  // fixed point widths
  localparam int VOLT_W  = 24;  // unsigned q2.22 voltage
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int W_W     = 40;  // diastolic-scaled voltage, signed q.22
  localparam int ACC_W   = 58;
  localparam int PRES_W  = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIVIDE,
    ST_M_RATIO,
    ST_M_SYS_HI,
    ST_M_SYS_LO,
    ST_M_DIA_HI,
    ST_M_DIA_LO,
    ST_FINISH,
    ST_OUT
  } aapp_state_e;

  // q16.16 offset lifted to the q.22 accumulator scale
  function automatic logic signed [ACC_W-1:0] off_scale(input logic [CFG_DATA_W-1:0] off);
    off_scale = {{(ACC_W-CFG_DATA_W-6){off[CFG_DATA_W-1]}}, off, 6'b0};
  endfunction

  // full product sign-extended to the accumulator
  function automatic logic signed [ACC_W-1:0] prod_ext(input logic [PROD_W-1:0] p);
    prod_ext = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // floor(p / 2^16) sign-extended to the accumulator
  function automatic logic signed [ACC_W-1:0] prod_shr16(input logic [PROD_W-1:0] p);
    prod_shr16 = {{(ACC_W-PROD_W+16){p[PROD_W-1]}}, p[PROD_W-1:16]};
  endfunction

  // truncate q.22 to an integer and clamp to 0..255
  function automatic logic [PRES_W-1:0] clamp_byte(input logic [ACC_W-1:0] t);
    if (t[ACC_W-1]) begin
      clamp_byte = '0;
    end else if (|t[ACC_W-2:22+PRES_W]) begin
      clamp_byte = '1;
    end else begin
      clamp_byte = t[22+PRES_W-1:22];
    end
  endfunction

endpackage

// ----- design/aapp_if.sv -----
interface aapp_in_if #(
  parameter int AdcBits = 12
);
  logic               valid;
  logic               ready;
  logic [AdcBits-1:0] adc_sample;
  logic               read_ok;

  modport source (output valid, output adc_sample, output read_ok, input ready);
  modport sink   (input valid, input adc_sample, input read_ok, output ready);
endinterface

interface aapp_out_if;
  logic                       valid;
  logic                       ready;
  logic [aapp_pkg::PRES_W-1:0] systolic;
  logic [aapp_pkg::PRES_W-1:0] diastolic;

  modport source (output valid, output systolic, output diastolic, input ready);
  modport sink   (input valid, input systolic, input diastolic, output ready);
endinterface

interface aapp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aapp_pkg::CFG_IDX_W-1:0]  index;
  logic [aapp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/averaged_adc_to_pressure_pair_unit.sv -----
// Averaged ADC to blood pressure pair. Each input word carries one converter sample and a
// read status; every input word produces exactly one output word (systolic, diastolic).
// A good read pushes the sample into a FILTER_DEPTH-deep ring (held in a small RAM) and
// averages the ring: v = sum / count * 3.3 / 2^ADC_BITS as unsigned q2.22. A failed read
// leaves the ring alone and uses v = 0. The pressures are clamp(trunc(gain*x + offset),
// 0, 255) with x = v for systolic and x = floor(v * diastolic scale) for diastolic; gains,
// offsets and scale are signed q16.16 registers written over the config channel (indexes
// 0..4: sys_gain, sys_bias, dia_gain, dia_bias, dia_scale; other indexes are
// dropped), and they must only change while the unit is idle. One word is worked at a
// time: a good read goes through the 24-step restoring divider that forms the average,
// then five passes through one shared 32x25 multiplier and the output load; a failed
// read skips the divider. The input channel is ready again as soon as the result is
// parked in the output register, so the next word can be taken while the previous result
// still waits downstream; only a result that finds the previous one still waiting stalls
// the unit until that one is taken.
module averaged_adc_to_pressure_pair_unit #(
  parameter int FILTER_DEPTH = 8,
  parameter int ADC_BITS     = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aapp_in_if.sink     in_ch,
  aapp_out_if.source  out_ch,
  aapp_cfg_if.sink    cfg_ch
);

  localparam int CntW     = $clog2(FILTER_DEPTH + 1);
  localparam int SlotW    = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int TotalW   = ADC_BITS + CntW;
  localparam int NumShift = 22 - ADC_BITS;   // 2^22 / 2^ADC_BITS folded into the numerator
  localparam int NumW     = CntW + 28;
  localparam int DenW     = CntW + 4;

  localparam int VW = aapp_pkg::VOLT_W;
  localparam int PW = aapp_pkg::PROD_W;
  localparam int WW = aapp_pkg::W_W;
  localparam int AW = aapp_pkg::ACC_W;
  localparam int BW = aapp_pkg::MUL_B_W;

  aapp_pkg::aapp_state_e state_q, state_d;

  // config registers
  logic [aapp_pkg::CFG_DATA_W-1:0] sys_gain_q, sys_off_q, dia_gain_q, dia_off_q, dia_scale_q;

  // filter state
  logic [TotalW-1:0] total_q;
  logic [CntW-1:0]   count_q;
  logic [SlotW-1:0]  slot_q;

  // latched input word
  logic [ADC_BITS-1:0] sample_q;
  logic                ok_q;

  // datapath
  logic [VW-1:0]  v_q;
  logic [WW-1:0]  w_q;
  logic [AW-1:0]  acc_q;
  logic [7:0]     sys_q, dia_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_sys_q, out_dia_q;

  logic                in_acc;
  logic                full;
  logic [ADC_BITS-1:0] ram_rdata;
  logic [ADC_BITS-1:0] old_sample;
  logic                ring_we;
  logic [TotalW+5:0]   tot33;
  logic [NumW-1:0]     div_num;
  logic [DenW-1:0]     div_den;
  logic                div_start, div_done;
  logic [VW-1:0]       div_quo;
  logic [aapp_pkg::MUL_A_W-1:0] mul_a;
  logic [BW-1:0]       mul_b;
  logic [PW-1:0]       mul_p;
  logic                out_free;

  assign in_ch.ready  = (state_q == aapp_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_q || out_ch.ready;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_gain_q  <= '0;
      sys_off_q   <= '0;
      dia_gain_q  <= '0;
      dia_off_q   <= '0;
      dia_scale_q <= aapp_pkg::DIA_SCALE_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        aapp_pkg::CFG_SYS_GAIN:  sys_gain_q  <= cfg_ch.data;
        aapp_pkg::CFG_SYS_BIAS:  sys_off_q   <= cfg_ch.data;
        aapp_pkg::CFG_DIA_GAIN:  dia_gain_q  <= cfg_ch.data;
        aapp_pkg::CFG_DIA_BIAS:  dia_off_q   <= cfg_ch.data;
        aapp_pkg::CFG_DIA_SCALE: dia_scale_q <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sample ring
  // the ram is read at the write slot every cycle, so the entry about to be
  // replaced is ready in the update state; entries are only trusted once the
  // ring is full, before that the slot was never written and counts as zero
  assign full       = (count_q == CntW'(FILTER_DEPTH));
  assign old_sample = full ? ram_rdata : '0;
  assign ring_we    = (state_q == aapp_pkg::ST_UPDATE) && ok_q;

  aapp_ram #(
    .Width (ADC_BITS),
    .Depth (FILTER_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      count_q <= '0;
      slot_q  <= '0;
    end else if (ring_we) begin
      total_q <= total_q - TotalW'(old_sample) + TotalW'(sample_q);
      if (!full) begin
        count_q <= count_q + 1'b1;
      end
      if (slot_q == SlotW'(FILTER_DEPTH - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- average
  // v = total * 33 * 2^(22 - ADC_BITS) / (count * 10), quotient always below 2^24
  assign tot33   = (TotalW+6)'({total_q, 5'b0}) + (TotalW+6)'(total_q);
  assign div_num = {tot33, {NumShift{1'b0}}};
  assign div_den = DenW'({count_q, 3'b0}) + DenW'({count_q, 1'b0});
  assign div_start = (state_q == aapp_pkg::ST_DIV_START);

  aapp_divider #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------- shared multiplier
  // operands are steered per state, the product shows up one state later
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      aapp_pkg::ST_M_RATIO: begin
        mul_a = dia_scale_q;
        mul_b = {1'b0, v_q};
      end
      aapp_pkg::ST_M_SYS_HI: begin
        mul_a = sys_gain_q;
        mul_b = BW'(v_q[VW-1:16]);
      end
      aapp_pkg::ST_M_SYS_LO: begin
        mul_a = sys_gain_q;
        mul_b = BW'(v_q[15:0]);
      end
      aapp_pkg::ST_M_DIA_HI: begin
        mul_a = dia_gain_q;
        mul_b = {w_q[WW-1], w_q[WW-1:16]};
      end
      aapp_pkg::ST_M_DIA_LO: begin
        mul_a = dia_gain_q;
        mul_b = BW'(w_q[15:0]);
      end
      default: ;
    endcase
  end

  aapp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_ch.adc_sample;
      ok_q     <= in_ch.read_ok;
    end
    case (state_q)
      aapp_pkg::ST_UPDATE: begin
        if (!ok_q) begin
          v_q <= '0;   // failed read maps the bare offsets
        end
      end
      aapp_pkg::ST_DIVIDE: begin
        if (div_done) begin
          v_q <= div_quo;
        end
      end
      aapp_pkg::ST_M_SYS_HI: begin
        w_q <= mul_p[WW+15:16];   // floor(v * scale / 2^16)
      end
      aapp_pkg::ST_M_SYS_LO: begin
        acc_q <= aapp_pkg::prod_ext(mul_p) + aapp_pkg::off_scale(sys_off_q);
      end
      aapp_pkg::ST_M_DIA_HI: begin
        sys_q <= aapp_pkg::clamp_byte(acc_q + aapp_pkg::prod_shr16(mul_p));
      end
      aapp_pkg::ST_M_DIA_LO: begin
        acc_q <= aapp_pkg::prod_ext(mul_p) + aapp_pkg::off_scale(dia_off_q);
      end
      aapp_pkg::ST_FINISH: begin
        dia_q <= aapp_pkg::clamp_byte(acc_q + aapp_pkg::prod_shr16(mul_p));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aapp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      aapp_pkg::ST_IDLE:      if (in_acc) state_d = aapp_pkg::ST_UPDATE;
      aapp_pkg::ST_UPDATE:    state_d = ok_q ? aapp_pkg::ST_DIV_START : aapp_pkg::ST_M_RATIO;
      aapp_pkg::ST_DIV_START: state_d = aapp_pkg::ST_DIVIDE;
      aapp_pkg::ST_DIVIDE:    if (div_done) state_d = aapp_pkg::ST_M_RATIO;
      aapp_pkg::ST_M_RATIO:   state_d = aapp_pkg::ST_M_SYS_HI;
      aapp_pkg::ST_M_SYS_HI:  state_d = aapp_pkg::ST_M_SYS_LO;
      aapp_pkg::ST_M_SYS_LO:  state_d = aapp_pkg::ST_M_DIA_HI;
      aapp_pkg::ST_M_DIA_HI:  state_d = aapp_pkg::ST_M_DIA_LO;
      aapp_pkg::ST_M_DIA_LO:  state_d = aapp_pkg::ST_FINISH;
      aapp_pkg::ST_FINISH:    state_d = aapp_pkg::ST_OUT;
      aapp_pkg::ST_OUT:       if (out_free) state_d = aapp_pkg::ST_IDLE;
      default:                state_d = aapp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == aapp_pkg::ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == aapp_pkg::ST_OUT) && out_free) begin
      out_sys_q <= sys_q;
      out_dia_q <= dia_q;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.systolic  = out_sys_q;
  assign out_ch.diastolic = out_dia_q;

endmodule

// ----- design/aapp_ram.sv -----
module aapp_ram #(
  parameter int Width = 12,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/aapp_divider.sv -----
module aapp_divider #(
  parameter int NumW = 32,
  parameter int DenW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NumW-1:0]               num_i,
  input  logic [DenW-1:0]               den_i,
  output logic                          done_o,
  output logic [aapp_pkg::VOLT_W-1:0]   quo_o
);

  localparam int QW   = aapp_pkg::VOLT_W;
  localparam int CntW = $clog2(QW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [QW-1:0]   quo_q;   // low numerator bits shift out, quotient bits shift in
  logic [DenW:0]   trial;
  logic            ge;
  logic [DenW:0]   diff;

  // restoring step: remainder stays below the divisor, one compare-subtract a cycle
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NumW-1:QW];
      quo_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- design/aapp_mul.sv -----
module aapp_mul (
  input  logic                         clk_i,
  input  logic [aapp_pkg::MUL_A_W-1:0] a_i,
  input  logic [aapp_pkg::MUL_B_W-1:0] b_i,
  output logic [aapp_pkg::PROD_W-1:0]  p_o
);

  logic signed [aapp_pkg::PROD_W-1:0] p_q;

  // signed 32x25 multiply, product registered
  always_ff @(posedge clk_i) begin
    p_q <= signed'(a_i) * signed'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- design/aapp_checker.sv -----
module aapp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] systolic_i,
  input logic [7:0] diastolic_i
);

  // a held result keeps its word until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(systolic_i) && $stable(diastolic_i))
    else $error("result word dropped or changed while stalled");

  // one word at a time: taking a word closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a word is in progress");

  // a fresh result only comes out of a busy unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |-> !$past(in_ready_i))
    else $error("result appeared without work in progress");

  // the input stays closed past the update state that follows an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 !in_ready_i)
    else $error("input reopened too early");

endmodule

bind averaged_adc_to_pressure_pair_unit aapp_checker u_aapp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .systolic_i  (out_ch.systolic),
  .diastolic_i (out_ch.diastolic)
);

// ----- verif/tb_averaged_adc_to_pressure_pair_unit.sv -----
`timescale 1ns / 1ps

module tb_averaged_adc_to_pressure_pair_unit;

  localparam int RING_DEPTH = 8;
  localparam int ADC_BITS   = 12;

  // 3.3 V reference kept as an exact ratio
  localparam longint VREF_NUM = 33;
  localparam longint VREF_DEN = 10;

  // indexes past the last register, the block drops these writes
  localparam logic [aapp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = aapp_pkg::CFG_DIA_SCALE + 3'd1;
  localparam logic [aapp_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST   = '1;

  // receiver back-pressure patterns, rotated through by a free-running counter
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct packed {
    logic [aapp_pkg::PRES_W-1:0] systolic;
    logic [aapp_pkg::PRES_W-1:0] diastolic;
  } pressure_pair_t;

  logic clk_i;
  logic rst_ni;

  aapp_in_if #(.AdcBits(ADC_BITS)) in_ch ();
  aapp_out_if                      out_ch ();
  aapp_cfg_if                      cfg_ch ();

  averaged_adc_to_pressure_pair_unit #(
    .FILTER_DEPTH(RING_DEPTH),
    .ADC_BITS    (ADC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predictor state: filter ring and calibration registers
  logic [ADC_BITS-1:0] ring_model [RING_DEPTH] = '{default: '0};
  logic [2:0]          slot_model  = '0;
  logic [3:0]          fill_model  = '0;
  logic [14:0]         total_model = '0;

  int sys_gain_q  = 0;
  int sys_bias_q  = 0;
  int dia_gain_q  = 0;
  int dia_bias_q  = 0;
  int dia_scale_q = aapp_pkg::DIA_SCALE_RESET;

  // pressure pairs still owed by the block, oldest first
  pressure_pair_t pending_pressures[$];

  int          mismatch_count = 0;
  int unsigned rx_cycle       = 0;

  // sender burst control; gap_limit of zero means back-to-back words
  int burst_left = 0;
  int gap_limit  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // clamp(trunc(gain * x + offset), 0, 255) with x in q.22, gain and offset in q16.16
  function automatic logic [aapp_pkg::PRES_W-1:0] map_to_pressure(input longint gain,
                                                                  input longint x,
                                                                  input longint offset);
    longint x_hi;
    longint x_lo;
    longint acc;
    x_hi = x >>> 16;
    x_lo = x & 64'sh0000_0000_0000_FFFF;
    acc  = gain * x_hi + ((gain * x_lo) >>> 16) + offset * 64;
    if (acc < 0) begin
      return '0;
    end
    acc = acc >>> 22;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  // push the sample through the averaging filter and queue the pressure pair it yields
  function automatic void predict_pressures(input logic [ADC_BITS-1:0] sample, input logic ok);
    longint         volts;
    longint         scaled;
    longint         num;
    longint         den;
    pressure_pair_t pair;
    volts = 0;
    if (ok) begin
      total_model        = total_model - 15'(ring_model[slot_model]) + 15'(sample);
      ring_model[slot_model] = sample;
      slot_model         = slot_model + 3'd1;
      if (fill_model < RING_DEPTH) begin
        fill_model = fill_model + 4'd1;
      end
      // average in volts, floored to unsigned q2.22
      num   = (longint'(total_model) * VREF_NUM) << 22;
      den   = (longint'(fill_model) * VREF_DEN) << ADC_BITS;
      volts = num / den;
    end
    // diastolic path scales the voltage first, floored at q.22
    scaled         = (volts * longint'(dia_scale_q)) >>> 16;
    pair.systolic  = map_to_pressure(longint'(sys_gain_q), volts, longint'(sys_bias_q));
    pair.diastolic = map_to_pressure(longint'(dia_gain_q), scaled, longint'(dia_bias_q));
    pending_pressures.push_back(pair);
  endfunction

  // output side: random-ish ready following a slowly rotating pattern
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_mode_e'(rx_cycle[10:9]))
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_COIN:     out_ch.ready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 5) == 0);
      RX_PERIODIC: out_ch.ready <= ((rx_cycle % 7) < 3);
      default:     out_ch.ready <= 1'b1;
    endcase
  end

  // compare every output word against the oldest prediction
  always @(posedge clk_i) begin
    pressure_pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pressures.size() == 0) begin
        $error("output word with nothing expected: systolic %0d diastolic %0d",
               out_ch.systolic, out_ch.diastolic);
        mismatch_count++;
      end else begin
        want = pending_pressures.pop_front();
        if (out_ch.systolic !== want.systolic) begin
          $error("systolic mismatch: expected %0d, got %0d", want.systolic, out_ch.systolic);
          mismatch_count++;
        end
        if (out_ch.diastolic !== want.diastolic) begin
          $error("diastolic mismatch: expected %0d, got %0d", want.diastolic,
                 out_ch.diastolic);
          mismatch_count++;
        end
      end
    end
  end

  // idle between bursts; back-to-back words keep valid high across the edge
  task automatic sender_pause();
    int gap;
    if (gap_limit == 0) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 10);
    gap        = $urandom_range(1, gap_limit);
    in_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // one input word; called right after a rising edge
  task automatic send_reading(input logic [ADC_BITS-1:0] sample, input logic ok);
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= sample;
    in_ch.read_ok    <= ok;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_pressures(sample, ok);
    sender_pause();
  endtask

  // stop sending and let every owed pressure pair drain out
  task automatic wait_for_all_pressures();
    if (in_ch.valid) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending_pressures.size() != 0) @(posedge clk_i);
    // let the block sit idle before any register write
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [aapp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [aapp_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      aapp_pkg::CFG_SYS_GAIN:  sys_gain_q  = value;
      aapp_pkg::CFG_SYS_BIAS:  sys_bias_q  = value;
      aapp_pkg::CFG_DIA_GAIN:  dia_gain_q  = value;
      aapp_pkg::CFG_DIA_BIAS:  dia_bias_q  = value;
      aapp_pkg::CFG_DIA_SCALE: dia_scale_q = value;
      default: ;
    endcase
  endtask

  task automatic program_calibration(input logic [aapp_pkg::CFG_DATA_W-1:0] s_gain, s_off,
                                     d_gain, d_off, d_scale);
    write_register(aapp_pkg::CFG_SYS_GAIN, s_gain);
    write_register(aapp_pkg::CFG_SYS_BIAS, s_off);
    write_register(aapp_pkg::CFG_DIA_GAIN, d_gain);
    write_register(aapp_pkg::CFG_DIA_BIAS, d_off);
    write_register(aapp_pkg::CFG_DIA_SCALE, d_scale);
  endtask

  // q16.16 coefficient: mostly a realistic window, sometimes the extremes or anything
  function automatic logic [aapp_pkg::CFG_DATA_W-1:0] pick_q16(input int unsigned span,
                                                               input int unsigned bias);
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(0, span) - bias;
    endcase
  endfunction

  // reset register values: zero gains and offsets force both pressures to zero
  task automatic test_reset_defaults();
    gap_limit = 0;
    send_reading(12'hFFF, 1'b0);
    send_reading(12'hFFF, 1'b1);
  endtask

  // plausible calibration; fill the ring past its depth and wrap the write slot
  task automatic test_directed_averaging();
    int i;
    wait_for_all_pressures();
    // 40 per volt + 10, 30 per volt + 5, diastolic scale 0.75
    program_calibration(32'd40 << 16, 32'd10 << 16, 32'd30 << 16, 32'd5 << 16, 32'h0000_C000);
    send_reading(12'h000, 1'b1);
    // failed read with a partly filled ring falls back to the offsets
    send_reading(12'hFFF, 1'b0);
    for (i = 0; i < RING_DEPTH; i++) begin
      send_reading(12'hFFF, 1'b1);
    end
    send_reading(12'hAAA, 1'b1);
    send_reading(12'h555, 1'b1);
    send_reading(12'h123, 1'b0);
    send_reading(12'h001, 1'b1);
    send_reading(12'h800, 1'b1);
    send_reading(12'h7FF, 1'b1);
  endtask

  // saturation both ways and the truncation edges near 0 and 256
  task automatic test_clamp_extremes();
    gap_limit = 6;
    wait_for_all_pressures();
    program_calibration(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0000);
    send_reading(12'h000, 1'b0);
    send_reading(12'hFFF, 1'b1);
    wait_for_all_pressures();
    program_calibration(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF);
    send_reading(12'h000, 1'b0);
    send_reading(12'hFFF, 1'b1);
    wait_for_all_pressures();
    // just below zero gives 0, just below 256 truncates to 255
    program_calibration(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h00FF_FFFF, 32'h0);
    send_reading(12'h800, 1'b1);
    wait_for_all_pressures();
    // exactly 256 clamps, exactly 255 passes; stray index must not disturb anything
    program_calibration(32'h0, 32'h0100_0000, 32'h0, 32'h00FF_0000,
                        aapp_pkg::DIA_SCALE_RESET);
    write_register(CFG_IDX_LAST, 32'hDEAD_BEEF);
    send_reading(12'h400, 1'b1);
  endtask

  // randomized calibration phases with slow-varying, noisy and edge samples
  task automatic test_random_phases();
    int                  phase;
    int                  item;
    int                  pause_at;
    int                  walk_level;
    logic [ADC_BITS-1:0] sample;
    walk_level = 2048;
    for (phase = 0; phase < 12; phase++) begin
      wait_for_all_pressures();
      program_calibration(pick_q16(140 << 16, 20 << 16), pick_q16(180 << 16, 60 << 16),
                          pick_q16(140 << 16, 20 << 16), pick_q16(180 << 16, 60 << 16),
                          pick_q16(3 << 16, 1 << 16));
      if ($urandom_range(0, 2) == 0) begin
        write_register(aapp_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED, CFG_IDX_LAST)),
                       $urandom);
      end
      gap_limit  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 40);
      burst_left = 0;
      pause_at   = $urandom_range(10, 80);
      for (item = 0; item < 92; item++) begin
        // hold off once per phase until the block has returned everything
        if (item == pause_at) begin
          wait_for_all_pressures();
        end
        case ($urandom_range(0, 9))
          0:       sample = 12'hFFF - ADC_BITS'($urandom_range(0, 3));
          1:       sample = ADC_BITS'($urandom_range(0, 3));
          2, 3:    sample = ADC_BITS'($urandom_range(0, 4095));
          default: begin
            // slowly drifting level like a real pressure cuff
            walk_level = walk_level + $urandom_range(0, 64) - 32;
            if (walk_level < 0) walk_level = 0;
            if (walk_level > 4095) walk_level = 4095;
            sample = ADC_BITS'(walk_level);
          end
        endcase
        send_reading(sample, $urandom_range(0, 99) >= 12);
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;
    in_ch.read_ok    <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed_averaging();
    test_clamp_extremes();
    test_random_phases();
    wait_for_all_pressures();

    if (mismatch_count == 0) begin
      $display("averaged_adc_to_pressure_pair_unit test passed");
    end else begin
      $display("averaged_adc_to_pressure_pair_unit test failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #25_000_000;
    $display("averaged_adc_to_pressure_pair_unit test failed");
    $finish;
  end

endmodule
